[hw/rtl/tmrp_pkg.sv]
// shared types and constants for the track motor ramp / pwm compare block
// no dependencies; used by tmrp_mul, track_motor_ramp_pwm_unit, tmrp_drive_checker and the testbench
package tmrp_pkg;

    // field and register widths
    localparam int ACTION_W = 2;
    localparam int STICK_W  = 11;
    localparam int MAG_W    = 10;
    localparam int SPEED_W  = 14;
    localparam int START_W  = 10;
    localparam int STEP_W   = 11;
    localparam int PERIOD_W = 10;
    localparam int CMP_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // shared multiplier
    localparam int MUL_OP_W = 18;
    localparam int PROD_W   = 2 * MUL_OP_W;

    typedef logic [MUL_OP_W-1:0] t_op;
    typedef logic [PROD_W-1:0]   t_prod;

    typedef struct packed {
        logic en;
        t_op  a;
        t_op  b;
    } t_mul_req;

    // actions
    localparam logic [ACTION_W-1:0] ACT_SET_MAPPED = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET_IMM    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK       = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd3;

    // configuration reset values
    localparam logic [START_W-1:0]  START_RST  = 10'd448;
    localparam logic [STEP_W-1:0]   ACCEL_RST  = 11'd6;
    localparam logic [STEP_W-1:0]   DECEL_RST  = 11'd16;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd50;

    // curve and scale constants
    localparam int STICK_KNEE  = 460;
    localparam int CURVE_KNEE  = 178;
    localparam int STICK_FULL  = 512;
    localparam int SPEED_SCALE = 10;
    localparam int CURVE_HI    = STICK_FULL - CURVE_KNEE;   // 334

    // reciprocals for constant division, exact over the value ranges used
    localparam int RECIP_KNEE     = 145889;  // ceil(2^26 / 460)
    localparam int RECIP_KNEE_SH  = 26;
    localparam int RECIP_SEG2     = 20165;   // ceil(2^20 / 52)
    localparam int RECIP_SEG2_SH  = 20;
    localparam int RECIP_SCALE    = 6554;    // ceil(2^16 / 10)
    localparam int RECIP_SCALE_SH = 16;
    localparam int FULL_SH        = 9;       // divide by 512

endpackage

[hw/rtl/tmrp_mul.sv]
// shared unsigned multiplier with registered product
// depends on tmrp_pkg for operand widths and the request struct
module tmrp_mul (
    input  logic               i_clk,
    input  tmrp_pkg::t_mul_req i_req,
    output tmrp_pkg::t_prod    o_prod
);

    tmrp_pkg::t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/track_motor_ramp_pwm_unit.sv]
// Track motor speed ramp with kick-start and H-bridge compare output, one track.
// Each accepted item runs a sequencer path chosen by its action: a set-immediate
// through IMM_A and IMM_B, a mapped set through MAP_A to MAP_D, a ramp tick through
// TICK_A to TICK_D (plus TICK_E when it has to step toward the target), an unused
// action straight to the output states. Every multiply goes through one shared
// 18x18 multiplier with a registered product, one sequencer state each, and the
// compare values take three states at the end of every action. The input is stalled
// from acceptance until the result is loaded into the output register; a result held
// there by a stalled output keeps the sequencer in OUT_C. A finished result may sit
// there while the next beat comes in. Depends on tmrp_pkg and tmrp_mul.
module track_motor_ramp_pwm_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [tmrp_pkg::ACTION_W-1:0]         i_action,
    input  logic signed [tmrp_pkg::STICK_W-1:0]   i_stick_value,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [tmrp_pkg::CMP_W-1:0]            o_compare_a,
    output logic [tmrp_pkg::CMP_W-1:0]            o_compare_b,
    output logic signed [tmrp_pkg::SPEED_W-1:0]   o_speed_now,
    output logic signed [tmrp_pkg::STICK_W-1:0]   o_speed_goal,
    // configuration
    input  logic                                  i_cfg_wr_en,
    input  logic [tmrp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tmrp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAP_A  = 4'd1;
    localparam logic [3:0] S_MAP_B  = 4'd2;
    localparam logic [3:0] S_MAP_C  = 4'd3;
    localparam logic [3:0] S_MAP_D  = 4'd4;
    localparam logic [3:0] S_IMM_A  = 4'd5;
    localparam logic [3:0] S_IMM_B  = 4'd6;
    localparam logic [3:0] S_TICK_A = 4'd7;
    localparam logic [3:0] S_TICK_B = 4'd8;
    localparam logic [3:0] S_TICK_C = 4'd9;
    localparam logic [3:0] S_TICK_D = 4'd10;
    localparam logic [3:0] S_TICK_E = 4'd11;
    localparam logic [3:0] S_OUT_A  = 4'd12;
    localparam logic [3:0] S_OUT_B  = 4'd13;
    localparam logic [3:0] S_OUT_C  = 4'd14;

    // configuration
    logic [tmrp_pkg::START_W-1:0]  r_start;
    logic [tmrp_pkg::STEP_W-1:0]   r_accel;
    logic [tmrp_pkg::STEP_W-1:0]   r_decel;
    logic [tmrp_pkg::PERIOD_W-1:0] r_period;

    // sequencer and item state
    logic [3:0]                        r_state;
    logic [3:0]                        n_state;
    logic [tmrp_pkg::MAG_W-1:0]        r_mag;
    logic                              r_neg;
    logic                              r_seg2;
    logic signed [tmrp_pkg::STICK_W-1:0] r_goal;
    logic signed [tmrp_pkg::SPEED_W-1:0] r_ramp;
    logic signed [tmrp_pkg::SPEED_W-1:0] r_tgt;
    logic signed [tmrp_pkg::SPEED_W-1:0] r_cur;
    logic [tmrp_pkg::SPEED_W-2:0]      r_kick;
    logic                              r_tick_done;

    // output register
    logic                              r_out_valid;
    logic [tmrp_pkg::CMP_W-1:0]        r_cmp_a;
    logic [tmrp_pkg::CMP_W-1:0]        r_cmp_b;
    logic signed [tmrp_pkg::SPEED_W-1:0] r_out_now;
    logic signed [tmrp_pkg::STICK_W-1:0] r_out_goal;

    tmrp_pkg::t_mul_req mul_req;
    tmrp_pkg::t_prod    prod;

    // combinational helpers
    logic                              in_take;
    logic                              out_free;
    logic [tmrp_pkg::MAG_W-1:0]        start_u;
    logic [tmrp_pkg::MAG_W-1:0]        in_mag;
    logic                              in_neg;
    logic [tmrp_pkg::STICK_W-1:0]      stick_abs;
    logic [tmrp_pkg::STICK_W-1:0]      goal_abs;
    logic [tmrp_pkg::SPEED_W-1:0]      ramp_abs;
    logic [tmrp_pkg::SPEED_W-1:0]      tgt_abs;
    logic [tmrp_pkg::SPEED_W-1:0]      cur_abs;
    logic [tmrp_pkg::MAG_W-1:0]        curve;
    logic [tmrp_pkg::STICK_W-1:0]      map_sum;
    logic signed [tmrp_pkg::STICK_W-1:0] map_goal;
    logic signed [tmrp_pkg::SPEED_W-1:0] prod_signed;
    logic [tmrp_pkg::SPEED_W-2:0]      kick_now;
    logic                              slowing;
    logic [tmrp_pkg::STEP_W-1:0]       step;
    logic signed [tmrp_pkg::SPEED_W:0] diff;
    logic signed [tmrp_pkg::SPEED_W:0] diff_neg;
    logic signed [tmrp_pkg::SPEED_W:0] step_w;
    logic signed [tmrp_pkg::SPEED_W-1:0] step_n;
    logic signed [tmrp_pkg::SPEED_W-1:0] cur_step;
    logic [tmrp_pkg::CMP_W-1:0]        ticks;
    logic [tmrp_pkg::CMP_W-1:0]        ticks_lim;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign start_u = (r_start > tmrp_pkg::START_W'(tmrp_pkg::STICK_FULL))
                   ? tmrp_pkg::START_W'(tmrp_pkg::STICK_FULL) : r_start;

    // saturate the stick to +-full scale
    assign stick_abs = i_stick_value[tmrp_pkg::STICK_W-1] ? (~i_stick_value + 11'd1)
                                                          : i_stick_value;
    assign in_neg = i_stick_value[tmrp_pkg::STICK_W-1];
    assign in_mag = (stick_abs > tmrp_pkg::STICK_W'(tmrp_pkg::STICK_FULL))
                  ? tmrp_pkg::MAG_W'(tmrp_pkg::STICK_FULL)
                  : stick_abs[tmrp_pkg::MAG_W-1:0];

    assign goal_abs = r_goal[tmrp_pkg::STICK_W-1] ? (~r_goal + 11'd1) : r_goal;
    assign ramp_abs = r_ramp[tmrp_pkg::SPEED_W-1] ? (~r_ramp + 14'd1) : r_ramp;
    assign tgt_abs  = r_tgt[tmrp_pkg::SPEED_W-1]  ? (~r_tgt + 14'd1)  : r_tgt;
    assign cur_abs  = r_cur[tmrp_pkg::SPEED_W-1]  ? (~r_cur + 14'd1)  : r_cur;

    // mapped curve: quotient of the segment division plus knee for the upper part
    assign curve = r_seg2
        ? tmrp_pkg::MAG_W'(tmrp_pkg::CURVE_KNEE)
          + prod[tmrp_pkg::RECIP_SEG2_SH +: tmrp_pkg::MAG_W]
        : prod[tmrp_pkg::RECIP_KNEE_SH +: tmrp_pkg::MAG_W];
    assign map_sum  = {1'b0, start_u} + {1'b0, prod[tmrp_pkg::FULL_SH +: tmrp_pkg::MAG_W]};
    assign map_goal = (r_mag == '0) ? '0
                    : (r_neg ? $signed(~map_sum + 11'd1) : $signed(map_sum));

    // product of a magnitude times ten, signed by r_neg or the goal sign
    assign prod_signed = (r_state == S_TICK_B ? r_goal[tmrp_pkg::STICK_W-1] : r_neg)
        ? $signed(~{1'b0, prod[tmrp_pkg::SPEED_W-2:0]} + 14'd1)
        : $signed({1'b0, prod[tmrp_pkg::SPEED_W-2:0]});
    assign kick_now = prod[tmrp_pkg::SPEED_W-2:0];

    // one ramp step toward the target
    assign slowing  = ((r_cur > 0) && (r_tgt < r_cur)) || ((r_cur < 0) && (r_tgt > r_cur));
    assign step     = slowing ? r_decel : r_accel;
    assign diff     = $signed({r_tgt[tmrp_pkg::SPEED_W-1], r_tgt})
                    - $signed({r_cur[tmrp_pkg::SPEED_W-1], r_cur});
    assign diff_neg = -diff;
    assign step_w   = $signed({4'b0, step});
    assign step_n   = $signed({3'b0, step});
    always_comb begin
        if (diff > 0) begin
            cur_step = (diff > step_w) ? (r_cur + step_n) : r_tgt;
        end else begin
            cur_step = (diff_neg > step_w) ? (r_cur - step_n) : r_tgt;
        end
    end

    assign ticks     = prod[tmrp_pkg::FULL_SH +: tmrp_pkg::CMP_W];
    assign ticks_lim = (ticks > r_period) ? r_period : ticks;

    // multiplier operand select
    always_comb begin
        mul_req.en = 1'b1;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (r_state)
            S_MAP_A: begin
                mul_req.a = r_seg2
                    ? tmrp_pkg::t_op'(r_mag - tmrp_pkg::MAG_W'(tmrp_pkg::STICK_KNEE))
                    : tmrp_pkg::t_op'(r_mag);
                mul_req.b = r_seg2 ? tmrp_pkg::t_op'(tmrp_pkg::CURVE_HI)
                                   : tmrp_pkg::t_op'(tmrp_pkg::CURVE_KNEE);
            end
            S_MAP_B: begin
                mul_req.a = prod[tmrp_pkg::MUL_OP_W-1:0];
                mul_req.b = r_seg2 ? tmrp_pkg::t_op'(tmrp_pkg::RECIP_SEG2)
                                   : tmrp_pkg::t_op'(tmrp_pkg::RECIP_KNEE);
            end
            S_MAP_C: begin
                mul_req.a = tmrp_pkg::t_op'(curve);
                mul_req.b = tmrp_pkg::t_op'(tmrp_pkg::MAG_W'(tmrp_pkg::STICK_FULL) - start_u);
            end
            S_IMM_A: begin
                mul_req.a = tmrp_pkg::t_op'(r_mag);
                mul_req.b = tmrp_pkg::t_op'(tmrp_pkg::SPEED_SCALE);
            end
            S_TICK_A: begin
                mul_req.a = tmrp_pkg::t_op'(goal_abs);
                mul_req.b = tmrp_pkg::t_op'(tmrp_pkg::SPEED_SCALE);
            end
            S_TICK_B: begin
                mul_req.a = tmrp_pkg::t_op'(start_u);
                mul_req.b = tmrp_pkg::t_op'(tmrp_pkg::SPEED_SCALE);
            end
            S_OUT_A: begin
                mul_req.a = tmrp_pkg::t_op'(ramp_abs);
                mul_req.b = tmrp_pkg::t_op'(tmrp_pkg::RECIP_SCALE);
            end
            S_OUT_B: begin
                mul_req.a = tmrp_pkg::t_op'(prod[tmrp_pkg::RECIP_SCALE_SH +: tmrp_pkg::MAG_W]);
                mul_req.b = tmrp_pkg::t_op'(r_period);
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    tmrp_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    case (i_action)
                        tmrp_pkg::ACT_SET_MAPPED: n_state = S_MAP_A;
                        tmrp_pkg::ACT_SET_IMM:    n_state = S_IMM_A;
                        tmrp_pkg::ACT_TICK:       n_state = S_TICK_A;
                        default:                  n_state = S_OUT_A;
                    endcase
                end
            end
            S_MAP_A:  n_state = S_MAP_B;
            S_MAP_B:  n_state = S_MAP_C;
            S_MAP_C:  n_state = S_MAP_D;
            S_MAP_D:  n_state = S_OUT_A;
            S_IMM_A:  n_state = S_IMM_B;
            S_IMM_B:  n_state = S_OUT_A;
            S_TICK_A: n_state = S_TICK_B;
            S_TICK_B: n_state = S_TICK_C;
            S_TICK_C: n_state = S_TICK_D;
            S_TICK_D: n_state = r_tick_done ? S_OUT_A : S_TICK_E;
            S_TICK_E: n_state = S_OUT_A;
            S_OUT_A:  n_state = S_OUT_B;
            S_OUT_B:  n_state = S_OUT_C;
            S_OUT_C:  n_state = out_free ? S_IDLE : S_OUT_C;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= tmrp_pkg::START_RST;
            r_accel     <= tmrp_pkg::ACCEL_RST;
            r_decel     <= tmrp_pkg::DECEL_RST;
            r_period    <= tmrp_pkg::PERIOD_RST;
            r_goal      <= '0;
            r_ramp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    tmrp_pkg::CFG_START:  r_start  <= i_cfg_data[tmrp_pkg::START_W-1:0];
                    tmrp_pkg::CFG_ACCEL:  r_accel  <= i_cfg_data;
                    tmrp_pkg::CFG_DECEL:  r_decel  <= i_cfg_data;
                    tmrp_pkg::CFG_PERIOD: r_period <= i_cfg_data[tmrp_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_MAP_D: r_goal <= map_goal;
                S_IMM_B: begin
                    r_ramp <= prod_signed;
                    r_goal <= r_neg ? $signed(~{1'b0, r_mag} + 11'd1) : $signed({1'b0, r_mag});
                end
                S_TICK_C: begin
                    // from rest: jump to kick speed, or straight to a small target
                    r_kick <= kick_now;
                    if (r_ramp == r_tgt) begin
                        r_tick_done <= 1'b1;
                    end else if ((r_ramp == 0) && (tgt_abs <= {1'b0, kick_now})) begin
                        r_ramp      <= r_tgt;
                        r_tick_done <= 1'b1;
                    end else begin
                        r_tick_done <= 1'b0;
                        if (r_ramp == 0) begin
                            r_cur <= r_tgt[tmrp_pkg::SPEED_W-1]
                                   ? $signed(~{1'b0, kick_now} + 14'd1)
                                   : $signed({1'b0, kick_now});
                        end else begin
                            r_cur <= r_ramp;
                        end
                    end
                end
                S_TICK_D: r_cur <= cur_step;
                S_TICK_E: begin
                    // snap to zero when stopping below start speed
                    if ((r_tgt == 0) && (cur_abs < {1'b0, r_kick})) begin
                        r_ramp <= '0;
                    end else begin
                        r_ramp <= r_cur;
                    end
                end
                default: ;
            endcase

            if (r_state == S_OUT_C && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mag    <= in_mag;
            r_neg    <= in_neg;
            r_seg2   <= in_mag > tmrp_pkg::MAG_W'(tmrp_pkg::STICK_KNEE);
        end
        if (r_state == S_TICK_B) begin
            r_tgt <= prod_signed;
        end
        if (r_state == S_OUT_C && out_free) begin
            r_cmp_a    <= (r_ramp > 0) ? ticks_lim : '0;
            r_cmp_b    <= (r_ramp < 0) ? ticks_lim : '0;
            r_out_now  <= r_ramp;
            r_out_goal <= r_goal;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_compare_a  = r_cmp_a;
    assign o_compare_b  = r_cmp_b;
    assign o_speed_now  = r_out_now;
    assign o_speed_goal = r_out_goal;

endmodule

[sim/tmrp_drive_checker.sv]
`timescale 1ns / 1ps
// watches the drive, result and register ports of track_motor_ramp_pwm_unit,
// tracks the ramp and target state, predicts each result and compares it
// depends on tmrp_pkg
module tmrp_drive_checker
    import tmrp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [STICK_W-1:0]  i_stick_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [CMP_W-1:0]           i_compare_a,
    input  logic [CMP_W-1:0]           i_compare_b,
    input  logic signed [SPEED_W-1:0]  i_speed_now,
    input  logic signed [STICK_W-1:0]  i_speed_goal,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_pending,
    output int                         o_fail_count
);

    typedef struct {
        logic [CMP_W-1:0]          cmp_a;
        logic [CMP_W-1:0]          cmp_b;
        logic signed [SPEED_W-1:0] spd_now;
        logic signed [STICK_W-1:0] spd_goal;
    } t_drive_word;

    t_drive_word due_q[$];

    // register copies and track state
    int start_cfg;
    int rise_cfg;
    int fall_cfg;
    int period_cfg;
    int goal_spd;   // stick units
    int cur_spd;    // tenfold scale

    task automatic report(input string msg);
        $display("tmrp_drive_checker: %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic int clamp_stick(input logic signed [STICK_W-1:0] v);
        int s;
        s = v;
        if (s > STICK_FULL)
            s = STICK_FULL;
        else if (s < -STICK_FULL)
            s = -STICK_FULL;
        return s;
    endfunction

    function automatic int kick_units();
        return (start_cfg > STICK_FULL) ? STICK_FULL : start_cfg;
    endfunction

    // two-segment stick curve lifted by the start offset
    function automatic int curve_goal(input int s);
        int mag, bend, base, lifted;
        if (s == 0)
            return 0;
        mag = (s < 0) ? -s : s;
        if (mag <= STICK_KNEE)
            bend = (mag * CURVE_KNEE) / STICK_KNEE;
        else
            bend = CURVE_KNEE + ((mag - STICK_KNEE) * (STICK_FULL - CURVE_KNEE)) /
                   (STICK_FULL - STICK_KNEE);
        base = kick_units();
        lifted = base + (bend * (STICK_FULL - base)) / STICK_FULL;
        return (s < 0) ? -lifted : lifted;
    endfunction

    function automatic void ramp_once();
        int aim, now, kick, diff, stp, mag;
        bit easing;
        aim = goal_spd * SPEED_SCALE;
        now = cur_spd;
        kick = kick_units() * SPEED_SCALE;
        if (now == aim)
            return;
        if (now == 0) begin
            mag = (aim < 0) ? -aim : aim;
            if (mag <= kick) begin
                cur_spd = aim;
                return;
            end
            now = (aim > 0) ? kick : -kick;
        end
        easing = (now > 0 && aim < now) || (now < 0 && aim > now);
        stp = easing ? fall_cfg : rise_cfg;
        diff = aim - now;
        if (diff > 0)
            now = (diff > stp) ? now + stp : aim;
        else
            now = (-diff > stp) ? now - stp : aim;
        // stopping below the kick speed drops straight to rest
        if (aim == 0) begin
            mag = (now < 0) ? -now : now;
            if (mag < kick)
                now = 0;
        end
        cur_spd = now;
    endfunction

    function automatic int duty_of(input int s);
        int mag, t;
        mag = (s < 0) ? -s : s;
        t = (mag * period_cfg) / STICK_FULL;
        return (t > period_cfg) ? period_cfg : t;
    endfunction

    function automatic t_drive_word next_word(input logic [ACTION_W-1:0] act,
                                              input logic signed [STICK_W-1:0] stick);
        t_drive_word w;
        int s, shown;
        s = clamp_stick(stick);
        case (act)
            ACT_SET_MAPPED: goal_spd = curve_goal(s);
            ACT_SET_IMM: begin
                goal_spd = s;
                cur_spd = s * SPEED_SCALE;
            end
            ACT_TICK: ramp_once();
            default: ;
        endcase
        shown = cur_spd / SPEED_SCALE;
        w.cmp_a = (shown > 0) ? CMP_W'(duty_of(shown)) : '0;
        w.cmp_b = (shown < 0) ? CMP_W'(duty_of(shown)) : '0;
        w.spd_now = cur_spd[SPEED_W-1:0];
        w.spd_goal = goal_spd[STICK_W-1:0];
        return w;
    endfunction

    task automatic check_word();
        t_drive_word w;
        if (due_q.size() == 0) begin
            report("result beat with nothing pending");
            return;
        end
        w = due_q.pop_front();
        if (i_compare_a !== w.cmp_a)
            report($sformatf("compare_a expected %0d got %0d", w.cmp_a, i_compare_a));
        if (i_compare_b !== w.cmp_b)
            report($sformatf("compare_b expected %0d got %0d", w.cmp_b, i_compare_b));
        if (i_speed_now !== w.spd_now)
            report($sformatf("speed_now expected %0d got %0d", w.spd_now, i_speed_now));
        if (i_speed_goal !== w.spd_goal)
            report($sformatf("speed_goal expected %0d got %0d", w.spd_goal, i_speed_goal));
    endtask

    initial begin
        o_pending = 0;
        o_fail_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_cfg = START_RST;
            rise_cfg = ACCEL_RST;
            fall_cfg = DECEL_RST;
            period_cfg = PERIOD_RST;
            goal_spd = 0;
            cur_spd = 0;
            due_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_START:  start_cfg = i_cfg_data[START_W-1:0];
                    CFG_ACCEL:  rise_cfg = i_cfg_data[STEP_W-1:0];
                    CFG_DECEL:  fall_cfg = i_cfg_data[STEP_W-1:0];
                    CFG_PERIOD: period_cfg = i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            // result first: a beat taken on the same edge is a later item
            if (i_out_valid && !i_out_stall)
                check_word();
            if (i_in_valid && !i_in_stall)
                due_q.push_back(next_word(i_action, i_stick_value));
        end
        o_pending = due_q.size();
    end

endmodule

[sim/tb_track_motor_ramp_pwm_unit.sv]
`timescale 1ns / 1ps
// top of the track_motor_ramp_pwm_unit testbench: clock, reset, stimulus, verdict
// depends on tmrp_pkg, track_motor_ramp_pwm_unit and tmrp_drive_checker
module tb_track_motor_ramp_pwm_unit;
    import tmrp_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_BEATS = 96;
    localparam int NUM_PHASES  = 7;
    localparam int HOLD_CYCLES = 400;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [ACTION_W-1:0]       i_action;
    logic signed [STICK_W-1:0] i_stick_value;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [CMP_W-1:0]          o_compare_a;
    logic [CMP_W-1:0]          o_compare_b;
    logic signed [SPEED_W-1:0] o_speed_now;
    logic signed [STICK_W-1:0] o_speed_goal;
    logic                      i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    int pending;
    int fail_count;
    int quiet_cycles;
    bit hold_req;
    bit calm_run;

    track_motor_ramp_pwm_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_stick_value (i_stick_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_compare_a   (o_compare_a),
        .o_compare_b   (o_compare_b),
        .o_speed_now   (o_speed_now),
        .o_speed_goal  (o_speed_goal),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tmrp_drive_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_stick_value (i_stick_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_compare_a   (o_compare_a),
        .i_compare_b   (o_compare_b),
        .i_speed_now   (o_speed_now),
        .i_speed_goal  (o_speed_goal),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: random stalls, or one long hold-off once it is requested
    initial begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !calm_run && ($urandom_range(99) < 20);
            end
        end
    end

    // ends the run when no beat and no register write is seen for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int wide_stick();
        if ($urandom_range(7) == 0)
            return int'($urandom_range(2047));
        return int'($urandom_range(1024)) - 512;
    endfunction

    // offers one beat, with a random gap first, and returns on the edge it is taken
    task automatic send_beat(input int act, input int stick);
        while (!calm_run && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= ACTION_W'(act);
        i_stick_value <= STICK_W'(stick);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic load_regs(input int start_v, input int rise_v,
                             input int fall_v, input int period_v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_START;
        i_cfg_data <= CFG_DATA_W'(start_v);
        @(posedge i_clk);
        i_cfg_index <= CFG_ACCEL;
        i_cfg_data <= CFG_DATA_W'(rise_v);
        @(posedge i_clk);
        i_cfg_index <= CFG_DECEL;
        i_cfg_data <= CFG_DATA_W'(fall_v);
        @(posedge i_clk);
        i_cfg_index <= CFG_PERIOD;
        i_cfg_data <= CFG_DATA_W'(period_v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly a target change followed by a run of ramp ticks, plus some noise
    task automatic run_drive(input int n_beats);
        int done, pick, ticks, k;
        done = 0;
        while (done < n_beats) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_beat($urandom_range(3), $urandom_range(2047));
                done++;
            end else begin
                if (pick < 60)
                    send_beat(ACT_SET_MAPPED, wide_stick());
                else if (pick < 75)
                    send_beat(ACT_SET_IMM, wide_stick());
                else
                    send_beat(ACT_SET_MAPPED, 0);
                ticks = $urandom_range(24, 1);
                for (k = 0; k < ticks; k++)
                    send_beat(ACT_TICK, $urandom_range(2047));
                done += ticks + 1;
            end
        end
    endtask

    initial begin
        int ph;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_action <= ACT_SET_MAPPED;
        i_stick_value <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_START;
        i_cfg_data <= '0;
        hold_req = 1'b0;
        calm_run = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on the reset register values
        send_beat(ACT_TICK, 0);             // at rest with no target
        send_beat(ACT_UNUSED, 1023);
        send_beat(ACT_SET_MAPPED, 1023);    // saturates high
        send_beat(ACT_TICK, 0);             // kick-start from rest
        send_beat(ACT_TICK, 0);
        send_beat(ACT_SET_MAPPED, 460);     // curve knee
        send_beat(ACT_SET_MAPPED, 461);
        send_beat(ACT_SET_MAPPED, -1024);   // saturates low
        send_beat(ACT_TICK, 0);             // heading back through zero
        send_beat(ACT_SET_IMM, 512);
        send_beat(ACT_SET_IMM, -513);
        send_beat(ACT_SET_IMM, 450);
        send_beat(ACT_SET_MAPPED, 0);
        send_beat(ACT_TICK, 0);
        send_beat(ACT_TICK, 0);             // falls below kick speed, snaps to rest
        send_beat(ACT_SET_IMM, 1);
        send_beat(ACT_SET_IMM, -1);
        send_beat(ACT_SET_MAPPED, 1);
        send_beat(ACT_SET_MAPPED, -1);
        send_beat(ACT_SET_MAPPED, 459);
        send_beat(ACT_SET_IMM, 40);
        send_beat(ACT_SET_MAPPED, 300);
        send_beat(ACT_TICK, 0);
        send_beat(ACT_SET_IMM, 0);
        send_beat(ACT_TICK, 0);             // already at rest on a zero target
        drain();

        for (ph = 1; ph <= NUM_PHASES; ph++) begin
            case (ph)
                1: load_regs(0, 0, 0, 0);
                2: load_regs(512, 2047, 2047, 1023);
                3: load_regs(1023, 1, 1, 1);
                5: load_regs(100, 200, 300, 777);
                7: load_regs($urandom_range(512), $urandom_range(64, 1),
                             $urandom_range(64, 1), $urandom_range(1023, 1));
                default: load_regs($urandom_range(2047), $urandom_range(2047),
                                   $urandom_range(2047), $urandom_range(2047));
            endcase
            calm_run = (ph == 2);
            if (ph == 3)
                hold_req = 1'b1;
            run_drive(PHASE_BEATS);
            drain();
        end
        calm_run = 1'b0;

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
